FILE: src/jsu_pkg.sv
package jsu_pkg;

  typedef enum logic [6:0] {
    MODE_IDLE   = 7'b0000001,
    MODE_STR    = 7'b0000010,
    MODE_ESC    = 7'b0000100,
    MODE_HEX1   = 7'b0001000,
    MODE_HIWAIT = 7'b0010000,
    MODE_HIBS   = 7'b0100000,
    MODE_HEX2   = 7'b1000000
  } mode_e;

  typedef enum logic [2:0] {
    ST_BYTE     = 3'd0,
    ST_CLOSED   = 3'd1,
    ST_NO_QUOTE = 3'd2,
    ST_BAD_ESC  = 3'd3,
    ST_BAD_HEX  = 3'd4,
    ST_UNTERM   = 3'd5
  } status_e;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  // 0x10000 - 0xDC00, folded into the pair sum
  localparam logic [20:0] PAIR_BIAS   = 21'h02400;

  // Up to four result words produced by one input byte; only the final one
  // may carry a non-zero status.
  typedef struct packed {
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
    status_e         status;
  } bundle_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } utf8_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] b;
    status_e    st;
    mode_e      next;
    logic       clear;
  } step_t;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
      [8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
      [8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
      default:       r = '0;
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.n    = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.n    = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.n    = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else begin
      r.n    = 3'd4;
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  function automatic step_t string_step(input logic [7:0] c);
    step_t s;
    s = '{emit: 1'b1, b: c, st: ST_BYTE, next: MODE_STR, clear: 1'b0};
    if (c == CH_QUOTE) begin
      s = '{emit: 1'b1, b: 8'h00, st: ST_CLOSED, next: MODE_IDLE, clear: 1'b1};
    end else if (c == CH_NUL) begin
      s = '{emit: 1'b1, b: 8'h00, st: ST_UNTERM, next: MODE_IDLE, clear: 1'b1};
    end else if (c == CH_BSLASH) begin
      s = '{emit: 1'b0, b: 8'h00, st: ST_BYTE, next: MODE_ESC, clear: 1'b0};
    end
    return s;
  endfunction

  function automatic step_t escape_step(input logic [7:0] c);
    step_t s;
    s = '{emit: 1'b1, b: c, st: ST_BYTE, next: MODE_STR, clear: 1'b0};
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: s.b = c;
      CH_B: s.b = 8'h08;
      CH_F: s.b = 8'h0C;
      CH_N: s.b = 8'h0A;
      CH_R: s.b = 8'h0D;
      CH_T: s.b = 8'h09;
      CH_U: s = '{emit: 1'b0, b: 8'h00, st: ST_BYTE, next: MODE_HEX1, clear: 1'b1};
      default: s = '{emit: 1'b1, b: 8'h00, st: ST_BAD_ESC, next: MODE_IDLE, clear: 1'b1};
    endcase
    return s;
  endfunction

endpackage

FILE: src/jsu_front.sv
module jsu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [7:0]       in_byte_i,
  output logic             wr_o,
  output jsu_pkg::bundle_t wr_data_o
);
  import jsu_pkg::*;

  mode_e       mode_q, mode_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  dc_q, dc_d;
  logic [15:0] hi_q, hi_d;

  logic [4:0]  hex_r;
  logic [15:0] full_w;
  utf8_t       cp_enc, hi_enc, pair_enc;
  logic [20:0] pair_cp;
  step_t       str_s, esc_s, app_s;
  logic        app_en;
  logic [1:0]  app_idx;

  logic [2:0]      n;
  logic [3:0][7:0] bytes;
  status_e         status;

  assign hex_r   = hex_value(in_byte_i);
  assign full_w  = {acc_q[11:0], hex_r[3:0]};
  assign cp_enc  = utf8_enc({5'd0, full_w});
  assign hi_enc  = utf8_enc({5'd0, hi_q});
  assign pair_cp = {1'b0, hi_q[9:0], 10'd0} + {5'd0, full_w} + PAIR_BIAS;
  assign pair_enc = utf8_enc(pair_cp);
  assign str_s   = string_step(in_byte_i);
  assign esc_s   = escape_step(in_byte_i);

  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    dc_d    = dc_q;
    hi_d    = hi_q;
    n       = 3'd0;
    bytes   = '0;
    status  = ST_BYTE;
    app_en  = 1'b0;
    app_s   = str_s;
    app_idx = 2'd0;

    case (mode_q)
      MODE_STR: begin
        app_en = 1'b1;
      end
      MODE_ESC: begin
        app_en = 1'b1;
        app_s  = esc_s;
      end
      MODE_HEX1, MODE_HEX2: begin
        if (!hex_r[4]) begin
          n        = 3'd1;
          status   = ST_BAD_HEX;
          mode_d   = MODE_IDLE;
          acc_d    = '0;
          dc_d     = '0;
          hi_d     = '0;
        end else if (dc_q != 2'd3) begin
          acc_d = full_w;
          dc_d  = dc_q + 2'd1;
        end else begin
          acc_d = '0;
          dc_d  = '0;
          if (mode_q == MODE_HEX2) begin
            hi_d   = '0;
            n      = pair_enc.n;
            bytes  = pair_enc.b;
            mode_d = MODE_STR;
          end else if (full_w >= HI_SURR_MIN && full_w <= HI_SURR_MAX) begin
            hi_d   = full_w;
            mode_d = MODE_HIWAIT;
          end else begin
            n      = cp_enc.n;
            bytes  = cp_enc.b;
            mode_d = MODE_STR;
          end
        end
      end
      MODE_HIWAIT, MODE_HIBS: begin
        if (mode_q == MODE_HIWAIT && in_byte_i == CH_BSLASH) begin
          mode_d = MODE_HIBS;
        end else if (mode_q == MODE_HIBS && in_byte_i == CH_U) begin
          mode_d = MODE_HEX2;
          acc_d  = '0;
          dc_d   = '0;
        end else begin
          // flush the lone high surrogate, then handle the byte as usual
          n       = hi_enc.n;
          bytes   = hi_enc.b;
          hi_d    = '0;
          app_en  = 1'b1;
          app_idx = 2'd3;
          if (mode_q == MODE_HIBS) begin
            app_s = esc_s;
          end
        end
      end
      default: begin
        acc_d = '0;
        dc_d  = '0;
        hi_d  = '0;
        if (in_byte_i == CH_QUOTE) begin
          mode_d = MODE_STR;
        end else begin
          n      = 3'd1;
          status = ST_NO_QUOTE;
          mode_d = MODE_IDLE;
        end
      end
    endcase

    if (app_en) begin
      mode_d = app_s.next;
      if (app_s.emit) begin
        bytes[app_idx] = app_s.b;
        status         = app_s.st;
        n              = n + 3'd1;
      end
      if (app_s.clear) begin
        acc_d = '0;
        dc_d  = '0;
        hi_d  = '0;
      end
    end
  end

  assign wr_o                = take_i && (n != 3'd0);
  assign wr_data_o.last_idx  = 2'(n - 3'd1);
  assign wr_data_o.bytes     = bytes;
  assign wr_data_o.status    = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      acc_q  <= '0;
      dc_q   <= '0;
      hi_q   <= '0;
    end else if (take_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      dc_q   <= dc_d;
      hi_q   <= hi_d;
    end
  end

endmodule

FILE: src/jsu_queue.sv
module jsu_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  jsu_pkg::bundle_t wr_data_i,
  output logic             full_o,
  input  logic             rd_i,
  output jsu_pkg::bundle_t rd_data_o,
  output logic             empty_o
);
  import jsu_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  bundle_t       mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_wr, do_rd;

  assign full_o    = (cnt_q == DEPTH_CNT);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

FILE: src/jsu_back.sv
module jsu_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  jsu_pkg::bundle_t head_i,
  input  logic             head_empty_i,
  output logic             head_rd_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [7:0]       out_byte_o,
  output logic [2:0]       status_o,
  output logic             last_o
);
  import jsu_pkg::*;

  logic [1:0] idx_q;
  logic       is_last;
  logic       take;

  assign is_last    = (idx_q == head_i.last_idx);
  assign empty_o    = head_empty_i;
  assign take       = pop_i && !head_empty_i;
  assign head_rd_o  = take && is_last;
  assign out_byte_o = head_i.bytes[idx_q];
  assign status_o   = is_last ? head_i.status : ST_BYTE;
  assign last_o     = is_last;

  // step through the words of the head bundle, release it after its last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (take) begin
      idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

FILE: src/json_string_unescape_utf8.sv
// JSON string literal unescaper with UTF-8 output.
// Input side is a queue write port: a text byte is taken on a rising edge
// with push high and full low, starting at the opening quote.
// Output side is a queue read port: while empty is low the oldest result
// word (out_byte_o, status_o, last_o) is shown; pop takes it.
// Each input byte yields zero to four words; last_o marks the final word of
// a byte, and status_o is non-zero only on a close or error word.
// The decoder handles a byte combinationally; its bundle, if it has words, is
// written into the queue on the edge that takes the byte. Throughput: one
// input byte per cycle while full is low, one result word per cycle while
// pop is high and empty is low; each pop drains one word of the head bundle,
// so a byte that yields several words holds its bundle for that many pops.
// The queue holds QUEUE_DEPTH bundles; full rises when it is full, so a
// stalled receiver holds the input back after that many bundles.
// Reset clears the decoder to idle (awaiting the opening quote), empties the
// queue and rewinds the output word index; nothing else needs clearing.
module json_string_unescape_utf8 #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic [2:0] status_o,
  output logic       last_o
);
  import jsu_pkg::*;

  logic    take;
  logic    q_wr, q_rd, q_empty;
  bundle_t q_wdata, q_rdata;

  assign take = push && !full;

  jsu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .in_byte_i (in_byte_i),
    .wr_o      (q_wr),
    .wr_data_o (q_wdata)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wdata),
    .full_o    (full),
    .rd_i      (q_rd),
    .rd_data_o (q_rdata),
    .empty_o   (q_empty)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_rdata),
    .head_empty_i (q_empty),
    .head_rd_o    (q_rd),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_byte_o   (out_byte_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule
